FILE: rtl/core/rl3_pkg.sv
// Package with the shared constants of the reciprocal lattice block.
`timescale 1ns / 1ps
package rl3_pkg;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int TWO_PI_FRAC = 60;
	localparam int K_LO_W = 32;
	localparam int K_HI_W = 31;
	localparam logic [62:0] TWO_PI_Q60 = 63'd7244019458077122842;
endpackage

FILE: rtl/core/reciprocal_lattice_3x3.sv
// Pipelined reciprocal lattice unit: 2*pi times the transposed inverse of a 3x3 matrix.
`timescale 1ns / 1ps
// The input channel (in_valid, in_stall) carries one 3x3 matrix per beat, nine signed
// components with DATA_WIDTH-8 fraction bits. The output channel (out_valid, out_stall)
// returns one beat per input beat, in order: nine reciprocal components with
// DATA_WIDTH/2 fraction bits, saturated, and a singular flag that zeroes them.
// Stages: eight for the cofactors, the determinant and the numerator, one for the
// overflow check, one for each quotient bit of the restoring divider, and the output
// register. Throughput is one beat per cycle while the receiver does not stall;
// every divider step has its own stage.
// Reset clears all valid bits; data registers are not reset.
// When the receiver stalls a valid result, the whole pipeline holds and in_stall
// rises in the same cycle; nothing is lost or repeated. Bubbles are not squeezed out.
module reciprocal_lattice_3x3 #(
	parameter int DATA_WIDTH = rl3_pkg::DATA_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [DATA_WIDTH-1:0] row1_x,
	input  logic signed [DATA_WIDTH-1:0] row1_y,
	input  logic signed [DATA_WIDTH-1:0] row1_z,
	input  logic signed [DATA_WIDTH-1:0] row2_x,
	input  logic signed [DATA_WIDTH-1:0] row2_y,
	input  logic signed [DATA_WIDTH-1:0] row2_z,
	input  logic signed [DATA_WIDTH-1:0] row3_x,
	input  logic signed [DATA_WIDTH-1:0] row3_y,
	input  logic signed [DATA_WIDTH-1:0] row3_z,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [DATA_WIDTH-1:0] recip1_x,
	output logic signed [DATA_WIDTH-1:0] recip1_y,
	output logic signed [DATA_WIDTH-1:0] recip1_z,
	output logic signed [DATA_WIDTH-1:0] recip2_x,
	output logic signed [DATA_WIDTH-1:0] recip2_y,
	output logic signed [DATA_WIDTH-1:0] recip2_z,
	output logic signed [DATA_WIDTH-1:0] recip3_x,
	output logic signed [DATA_WIDTH-1:0] recip3_y,
	output logic signed [DATA_WIDTH-1:0] recip3_z,
	output logic singular
);
	localparam int W = DATA_WIDTH;
	localparam int CW = 2 * W + 1;
	localparam int CA = 2 * W;
	localparam int DW = 3 * W + 3;
	localparam int KL = rl3_pkg::K_LO_W;
	localparam int KH = rl3_pkg::K_HI_W;
	localparam int PW = KL + KH + CA;
	localparam int SH = (W - 8) + (W / 2) + 1;
	localparam int RW = DW + W + rl3_pkg::TWO_PI_FRAC + 2;
	localparam logic [KL-1:0] K_LO = rl3_pkg::TWO_PI_Q60[KL-1:0];
	localparam logic [KH-1:0] K_HI = rl3_pkg::TWO_PI_Q60[KL+KH-1:KL];
	localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MIN_MAG = {1'b1, {(W-1){1'b0}}};

	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Front stages.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic signed [W-1:0] m_s1 [0:8];
	logic signed [2*W-1:0] pa_s2 [0:8];
	logic signed [2*W-1:0] pb_s2 [0:8];
	logic signed [W-1:0] m0_s2 [0:2];
	logic signed [CW-1:0] cof_s3 [0:8];
	logic signed [W-1:0] m0_s3 [0:2];
	logic signed [CW-1:0] cof_s4 [0:8];
	logic signed [CW-1:0] dl_s4 [0:2];
	logic signed [CW-1:0] dh_s4 [0:2];
	logic signed [DW-1:0] det_s5;
	logic [CA-1:0] ca_s5 [0:8];
	logic cn_s5 [0:8];
	logic [DW-1:0] da_s6;
	logic dn_s6, sing_s6;
	logic [KL+W-1:0] pll_s6 [0:8];
	logic [KL+W-1:0] plh_s6 [0:8];
	logic [KH+W-1:0] phl_s6 [0:8];
	logic [KH+W-1:0] phh_s6 [0:8];
	logic cn_s6 [0:8];
	logic [PW-1:0] p_s7 [0:8];
	logic [DW-1:0] da_s7;
	logic dn_s7, sing_s7;
	logic cn_s7 [0:8];
	logic [RW-1:0] a_s8 [0:8];
	logic [RW-1:0] b_s8;
	logic ng_s8 [0:8];
	logic sing_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	logic signed [DW-1:0] det_sum;
	always_comb begin
		det_sum = '0;
		for (int j = 0; j < 3; j++) begin
			det_sum = det_sum + (DW'(dh_s4[j]) <<< W) + DW'(dl_s4[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s1[0] <= row1_x;
			m_s1[1] <= row1_y;
			m_s1[2] <= row1_z;
			m_s1[3] <= row2_x;
			m_s1[4] <= row2_y;
			m_s1[5] <= row2_z;
			m_s1[6] <= row3_x;
			m_s1[7] <= row3_y;
			m_s1[8] <= row3_z;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pa_s2[i*3+j] <= m_s1[((i+1)%3)*3+(j+1)%3] * m_s1[((i+2)%3)*3+(j+2)%3];
					pb_s2[i*3+j] <= m_s1[((i+1)%3)*3+(j+2)%3] * m_s1[((i+2)%3)*3+(j+1)%3];
				end
			end
			for (int j = 0; j < 3; j++) begin
				m0_s2[j] <= m_s1[j];
				m0_s3[j] <= m0_s2[j];
				dl_s4[j] <= m0_s3[j] * $signed({1'b0, cof_s3[j][W-1:0]});
				dh_s4[j] <= m0_s3[j] * $signed(cof_s3[j][CW-1:W]);
			end
			for (int e = 0; e < 9; e++) begin
				cof_s3[e] <= CW'(pa_s2[e]) - CW'(pb_s2[e]);
				cof_s4[e] <= cof_s3[e];
				cn_s5[e] <= cof_s4[e][CW-1];
				ca_s5[e] <= cof_s4[e][CW-1] ? CA'(-cof_s4[e]) : CA'(cof_s4[e]);
				pll_s6[e] <= K_LO * ca_s5[e][W-1:0];
				plh_s6[e] <= K_LO * ca_s5[e][CA-1:W];
				phl_s6[e] <= K_HI * ca_s5[e][W-1:0];
				phh_s6[e] <= K_HI * ca_s5[e][CA-1:W];
				cn_s6[e] <= cn_s5[e];
				p_s7[e] <= PW'(pll_s6[e]) + (PW'(plh_s6[e]) << W) + (PW'(phl_s6[e]) << KL)
					+ (PW'(phh_s6[e]) << (KL + W));
				cn_s7[e] <= cn_s6[e];
				a_s8[e] <= (RW'(p_s7[e]) << SH) + (RW'(da_s7) << rl3_pkg::TWO_PI_FRAC);
				ng_s8[e] <= cn_s7[e] ^ dn_s7;
			end
			det_s5 <= det_sum;
			dn_s6 <= det_s5[DW-1];
			sing_s6 <= (det_s5 == '0);
			da_s6 <= det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);
			da_s7 <= da_s6;
			dn_s7 <= dn_s6;
			sing_s7 <= sing_s6;
			b_s8 <= RW'(da_s7) << (rl3_pkg::TWO_PI_FRAC + 1);
			sing_s8 <= sing_s7;
		end
	end

	// Divider: stage 0 checks for overflow, then one quotient bit per stage, MSB first.
	logic vd_q [0:W];
	logic [RW-1:0] rem_q [0:W][0:8];
	logic [W-1:0] quo_q [0:W][0:8];
	logic hg_q [0:W][0:8];
	logic ng_q [0:W][0:8];
	logic [RW-1:0] den_q [0:W];
	logic sg_q [0:W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t <= W; t++) begin
				vd_q[t] <= 1'b0;
			end
		end else if (adv) begin
			vd_q[0] <= v_s8;
			for (int t = 0; t < W; t++) begin
				vd_q[t+1] <= vd_q[t];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_q[0] <= b_s8;
			sg_q[0] <= sing_s8;
			for (int e = 0; e < 9; e++) begin
				rem_q[0][e] <= a_s8[e];
				quo_q[0][e] <= '0;
				hg_q[0][e] <= (a_s8[e] >= (b_s8 << W));
				ng_q[0][e] <= ng_s8[e];
			end
			for (int t = 0; t < W; t++) begin
				den_q[t+1] <= den_q[t];
				sg_q[t+1] <= sg_q[t];
				for (int e = 0; e < 9; e++) begin
					hg_q[t+1][e] <= hg_q[t][e];
					ng_q[t+1][e] <= ng_q[t][e];
					if (rem_q[t][e] >= (den_q[t] << (W - 1 - t))) begin
						rem_q[t+1][e] <= rem_q[t][e] - (den_q[t] << (W - 1 - t));
						quo_q[t+1][e] <= {quo_q[t][e][W-2:0], 1'b1};
					end else begin
						rem_q[t+1][e] <= rem_q[t][e];
						quo_q[t+1][e] <= {quo_q[t][e][W-2:0], 1'b0};
					end
				end
			end
		end
	end

	// Output register with saturation.
	logic ov_q;
	logic [W-1:0] res_q [0:8];
	logic sing_q;
	logic [W-1:0] res_d [0:8];

	always_comb begin
		for (int e = 0; e < 9; e++) begin
			if (sg_q[W]) begin
				res_d[e] = '0;
			end else if (ng_q[W][e]) begin
				if (hg_q[W][e] || quo_q[W][e] > MIN_MAG) begin
					res_d[e] = MIN_MAG;
				end else begin
					res_d[e] = -quo_q[W][e];
				end
			end else if (hg_q[W][e] || quo_q[W][e] > MAX_POS) begin
				res_d[e] = MAX_POS;
			end else begin
				res_d[e] = quo_q[W][e];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (adv) begin
			ov_q <= vd_q[W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sing_q <= sg_q[W];
			for (int e = 0; e < 9; e++) begin
				res_q[e] <= res_d[e];
			end
		end
	end

	assign out_valid = ov_q;
	assign singular = sing_q;
	assign recip1_x = res_q[0];
	assign recip1_y = res_q[1];
	assign recip1_z = res_q[2];
	assign recip2_x = res_q[3];
	assign recip2_y = res_q[4];
	assign recip2_z = res_q[5];
	assign recip3_x = res_q[6];
	assign recip3_y = res_q[7];
	assign recip3_z = res_q[8];

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && singular) |-> (recip1_x == '0 && recip2_y == '0 && recip3_z == '0))
		else $error("singular result carries nonzero components");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled output");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted beat did not enter the pipeline");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(recip1_x) && $stable(singular)))
		else $error("stalled result changed");
endmodule
